// File: src/spin_counting_linear_actuator_unit_defines.svh
// Assertion macros used by the spin counting linear actuator controller.
`ifndef SPIN_COUNTING_LINEAR_ACTUATOR_UNIT_DEFINES_SVH
`define SPIN_COUNTING_LINEAR_ACTUATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SCLA_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// condition must never be seen outside reset
`define SCLA_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);
`else
`define SCLA_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define SCLA_NEVER(lbl, clk_s, rstn_s, cond, msg)
`endif
`endif

// File: src/scla_pkg.sv
// Shared types, constants and codes of the spin counting linear actuator.
`timescale 1ns / 1ps
package scla_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int SPIN_WIDTH_DEF  = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODULE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAG_EN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAG_CA     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAG_CB     = 3'd6;

	// register reset values
	localparam logic [30:0]        RST_MODULE   = 31'd65536;
	localparam logic [30:0]        RST_JUMP_THR = 31'd19661;
	localparam logic [30:0]        RST_HYST     = 31'd0;
	localparam logic signed [31:0] RST_GAIN     = 32'sd65536;

	// direction codes, signed two bits
	localparam logic [1:0] DIR_ZERO = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	// multiplier operand selection
	localparam logic [1:0] MS_SPIN = 2'd0;
	localparam logic [1:0] MS_GAIN = 2'd1;
	localparam logic [1:0] MS_CA   = 2'd2;
	localparam logic [1:0] MS_CB   = 2'd3;

	// destination of a rounded product
	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_V    = 2'd1;
	localparam logic [1:0] RD_P    = 2'd2;
	localparam logic [1:0] RD_Q    = 2'd3;

	typedef struct packed {
		logic [30:0]        module_cfg;
		logic [30:0]        jump_threshold;
		logic [30:0]        hysteresis;
		logic signed [31:0] gain;
		logic               lag_enable;
		logic signed [31:0] lag_ca;
		logic signed [31:0] lag_cb;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       calc_x;
		logic       update;
		logic       zero_v;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       sum_en;
		logic [1:0] rnd_dst;
		logic       lag_sum;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clear;
		logic lag_en;
	} dp_stat_t;

endpackage

// File: src/scla_datapath.sv
// Datapath: word registers, tracking logic, shared multiplier, rounding and lag.
`timescale 1ns / 1ps
module scla_datapath import scla_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int SPIN_WIDTH  = SPIN_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] in_data,  // sample, bias
	input  logic [3:0]  in_user,  // track_enable, clear, allowed_direction
	input  cfg_t        cfg,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [31:0] out_data  // output_value
);

	localparam int VW = VALUE_WIDTH;
	localparam int SW = SPIN_WIDTH;
	localparam int AW = 33;
	localparam int BW = (VW + 1 > SW) ? VW + 1 : SW;
	localparam int PW = AW + BW;
	localparam int WW = PW + 2;
	localparam int CW = (VW + 1 > 31) ? VW + 2 : 32;
	localparam int XW = (VW > 32) ? VW : 33;

	localparam logic signed [WW-1:0] VMAX_W = {{(WW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic signed [WW-1:0] VMIN_W = ~VMAX_W;
	localparam logic [PW:0]          LIM_POS = (PW+1)'({(VW-1){1'b1}});
	localparam logic signed [XW-1:0] OMAX_X = {{(XW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [XW-1:0] OMIN_X = ~OMAX_X;
	localparam logic [SW-1:0]        SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0]        SMIN = {1'b1, {(SW-1){1'b0}}};

	function automatic logic signed [VW-1:0] sat_v(input logic signed [WW-1:0] x);
		if (x > VMAX_W) begin
			return VMAX_W[VW-1:0];
		end else if (x < VMIN_W) begin
			return VMIN_W[VW-1:0];
		end
		return x[VW-1:0];
	endfunction

	// round magnitude to nearest, ties away from zero, then saturate
	function automatic logic signed [VW-1:0] rnd_v(input logic signed [PW-1:0] p,
		input logic sh30);
		logic          neg;
		logic [PW:0]   m;
		logic [PW:0]   r;
		logic [PW:0]   lim;
		neg = p[PW-1];
		m   = {1'b0, (neg ? -p : p)};
		if (sh30) begin
			m = m + (PW+1)'(32'h2000_0000);
			r = m >> 30;
		end else begin
			m = m + (PW+1)'(32'h0000_8000);
			r = m >> 16;
		end
		lim = LIM_POS + (PW+1)'(neg);
		if (r > lim) begin
			r = lim;
		end
		return VW'(neg ? -r : r);
	endfunction

	function automatic logic [31:0] sat_o(input logic signed [VW-1:0] x);
		logic signed [XW-1:0] xe;
		xe = XW'(x);
		if (xe > OMAX_X) begin
			return OMAX_X[31:0];
		end else if (xe < OMIN_X) begin
			return OMIN_X[31:0];
		end
		return xe[31:0];
	endfunction

	// word registers
	logic signed [VW-1:0] sample_q;
	logic signed [31:0]   bias_q;
	logic                 track_q;
	logic                 clear_q;
	logic [1:0]           dir_q;
	logic signed [VW-1:0] x_q;
	logic signed [PW-1:0] prod_q;
	logic signed [VW-1:0] v_q;
	logic signed [VW-1:0] p_q;
	logic signed [VW-1:0] q_q;
	logic [31:0]          out_q;

	// tracking and lag state
	logic signed [VW-1:0] held_q;
	logic signed [VW-1:0] bo_q;
	logic [SW-1:0]        spin_q;
	logic [1:0]           ldir_q;
	logic signed [VW-1:0] pi_q;
	logic signed [VW-1:0] po_q;

	logic signed [31:0]   in_sample;
	logic signed [31:0]   in_bias;
	logic [1:0]           in_dir;

	logic signed [VW:0]   d_w;
	logic [VW:0]          ad;
	logic [CW-1:0]        ad_c;
	logic                 d_neg;
	logic                 past_hyst;
	logic                 within_thr;
	logic                 at_jump;
	logic [1:0]           dir_new;
	logic                 follow;
	logic signed [VW-1:0] bo_sum;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [VW:0]   lag_in;
	logic signed [VW-1:0] rnd_res;
	logic signed [VW-1:0] sum_res;
	logic signed [VW-1:0] lag_res;

	assign in_sample = $signed(in_data[31:0]);
	assign in_bias   = $signed(in_data[63:32]);
	// pattern 10 counts as minus one
	assign in_dir    = in_user[3] ? DIR_NEG : (in_user[2] ? DIR_POS : DIR_ZERO);

	always_comb begin
		d_w        = (VW+1)'(x_q) - (VW+1)'(held_q);
		d_neg      = d_w[VW];
		ad         = d_neg ? -d_w : d_w;
		ad_c       = CW'(ad);
		past_hyst  = ad_c >= CW'(cfg.hysteresis);
		within_thr = ad_c <= CW'(cfg.jump_threshold);
		at_jump    = ad_c >= CW'(cfg.jump_threshold);
		dir_new    = ldir_q;
		if (within_thr && d_w != '0) begin
			dir_new = d_neg ? DIR_NEG : DIR_POS;
		end
		follow     = (dir_q == DIR_ZERO) || (dir_q == dir_new);
		bo_sum     = sat_v(WW'(bo_q) + WW'(d_w));
	end

	always_comb begin
		lag_in = (VW+1)'(v_q) + (VW+1)'(pi_q);
		case (cmd.mul_sel)
			MS_SPIN: begin
				mul_a = $signed({2'b00, cfg.module_cfg});
				mul_b = BW'($signed(spin_q));
			end
			MS_GAIN: begin
				mul_a = AW'(cfg.gain);
				mul_b = BW'(v_q);
			end
			MS_CA: begin
				mul_a = AW'(cfg.lag_ca);
				mul_b = BW'(lag_in);
			end
			default: begin
				mul_a = AW'(cfg.lag_cb);
				mul_b = BW'(po_q);
			end
		endcase
	end

	assign rnd_res = rnd_v(prod_q, cmd.rnd_dst != RD_V);
	assign sum_res = sat_v(WW'(bias_q) + WW'(held_q) + WW'(prod_q));
	assign lag_res = sat_v(WW'(p_q) + WW'(q_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			bo_q   <= '0;
			spin_q <= '0;
			ldir_q <= DIR_ZERO;
			pi_q   <= '0;
			po_q   <= '0;
		end else begin
			if (cmd.update) begin
				if (clear_q) begin
					held_q <= '0;
					bo_q   <= '0;
					spin_q <= '0;
					ldir_q <= DIR_ZERO;
				end else if (track_q && past_hyst) begin
					ldir_q <= dir_new;
					if (follow) begin
						held_q <= x_q;
						if (at_jump) begin
							if (d_neg) begin
								if (spin_q != SMAX) begin
									spin_q <= spin_q + 1'b1;
								end
							end else if (spin_q != SMIN) begin
								spin_q <= spin_q - 1'b1;
							end
						end
					end else if (dir_new != DIR_ZERO) begin
						bo_q <= bo_sum;
					end
				end
			end
			if (cmd.lag_sum) begin
				pi_q <= v_q;
				po_q <= lag_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sat_v(WW'(in_sample));
			bias_q   <= in_bias;
			track_q  <= in_user[0];
			clear_q  <= in_user[1];
			dir_q    <= in_dir;
		end
		if (cmd.calc_x) begin
			x_q <= sat_v(WW'(sample_q) - WW'(bo_q));
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.zero_v) begin
			v_q <= '0;
		end else if (cmd.sum_en) begin
			v_q <= sum_res;
		end else if (cmd.rnd_dst == RD_V) begin
			v_q <= rnd_res;
		end
		if (cmd.rnd_dst == RD_P) begin
			p_q <= rnd_res;
		end
		if (cmd.rnd_dst == RD_Q) begin
			q_q <= rnd_res;
		end
		if (cmd.out_load) begin
			out_q <= sat_o(cfg.lag_enable ? po_q : v_q);
		end
	end

	assign stat.clear  = clear_q;
	assign stat.lag_en = cfg.lag_enable;
	assign out_data    = out_q;

endmodule

// File: src/scla_ctrl.sv
// Controller: sequences one word through the datapath and owns the handshakes.
`timescale 1ns / 1ps
`include "spin_counting_linear_actuator_unit_defines.svh"
module scla_ctrl import scla_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TRK1 = 4'd1;
	localparam logic [3:0] ST_TRK2 = 4'd2;
	localparam logic [3:0] ST_ZERO = 4'd3;
	localparam logic [3:0] ST_MULS = 4'd4;
	localparam logic [3:0] ST_SUM  = 4'd5;
	localparam logic [3:0] ST_MULG = 4'd6;
	localparam logic [3:0] ST_RNDG = 4'd7;
	localparam logic [3:0] ST_MULA = 4'd8;
	localparam logic [3:0] ST_RNDA = 4'd9;
	localparam logic [3:0] ST_MULB = 4'd10;
	localparam logic [3:0] ST_RNDB = 4'd11;
	localparam logic [3:0] ST_LSUM = 4'd12;
	localparam logic [3:0] ST_OUT  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = ST_TRK1;
				end
			end
			ST_TRK1: begin
				cmd.calc_x = 1'b1;
				state_nx   = ST_TRK2;
			end
			ST_TRK2: begin
				cmd.update = 1'b1;
				state_nx   = stat.clear ? ST_ZERO : ST_MULS;
			end
			ST_ZERO: begin
				cmd.zero_v = 1'b1;
				state_nx   = stat.lag_en ? ST_MULA : ST_OUT;
			end
			ST_MULS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SPIN;
				state_nx    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_nx   = ST_MULG;
			end
			ST_MULG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_GAIN;
				state_nx    = ST_RNDG;
			end
			ST_RNDG: begin
				cmd.rnd_dst = RD_V;
				state_nx    = stat.lag_en ? ST_MULA : ST_OUT;
			end
			ST_MULA: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_CA;
				state_nx    = ST_RNDA;
			end
			ST_RNDA: begin
				cmd.rnd_dst = RD_P;
				state_nx    = ST_MULB;
			end
			ST_MULB: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_CB;
				state_nx    = ST_RNDB;
			end
			ST_RNDB: begin
				cmd.rnd_dst = RD_Q;
				state_nx    = ST_LSUM;
			end
			ST_LSUM: begin
				cmd.lag_sum = 1'b1;
				state_nx    = ST_OUT;
			end
			ST_OUT: begin
				// output register free, or its word leaves this cycle
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SCLA_ASSERT(a_accept_starts, clk, arst_n, s_tvalid && s_tready |=> state_q == ST_TRK1, "accepted word did not start tracking")
	`SCLA_NEVER(a_load_vs_out, clk, arst_n, cmd.load && cmd.out_load, "input load and output load together")
	`SCLA_ASSERT(a_out_valid, clk, arst_n, cmd.out_load |=> m_tvalid, "loaded result not presented")
	`SCLA_ASSERT(a_lag_gated, clk, arst_n, state_q == ST_MULA |-> stat.lag_en, "lag step run with lag off")

endmodule

// File: src/spin_counting_linear_actuator_unit.sv
// Top level of the spin counting linear actuator: configuration registers and core.
// One word is in flight at a time: s_tready is high only while the sequencer is idle, and the
// sequencer steps every product through the single shared multiplier; the lag adds steps
// and a clear word skips the spin and gain products.
// The next word is taken while the previous result still waits in the output register.
// Reset (arst_n, asynchronous): registers to defaults, all tracking and lag state to zero.
`timescale 1ns / 1ps
module spin_counting_linear_actuator_unit import scla_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int SPIN_WIDTH  = SPIN_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,   // sample [31:0], bias [63:32]
	input  logic [3:0]            s_tuser,   // track_enable [0], clear [1], allowed_direction [3:2]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // output_value [31:0]
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.module_cfg     <= RST_MODULE;
			cfg_q.jump_threshold <= RST_JUMP_THR;
			cfg_q.hysteresis     <= RST_HYST;
			cfg_q.gain           <= RST_GAIN;
			cfg_q.lag_enable     <= 1'b0;
			cfg_q.lag_ca         <= '0;
			cfg_q.lag_cb         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULE:     cfg_q.module_cfg     <= cfg_wdata[30:0];
				REG_JUMP_THR:   cfg_q.jump_threshold <= cfg_wdata[30:0];
				REG_HYSTERESIS: cfg_q.hysteresis     <= cfg_wdata[30:0];
				REG_GAIN:       cfg_q.gain           <= $signed(cfg_wdata);
				REG_LAG_EN:     cfg_q.lag_enable     <= cfg_wdata[0];
				REG_LAG_CA:     cfg_q.lag_ca         <= $signed(cfg_wdata);
				REG_LAG_CB:     cfg_q.lag_cb         <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	scla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scla_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.SPIN_WIDTH  (SPIN_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (m_tdata)
	);

endmodule
